// ===== hdl/prt_pkg.sv =====
// Shared types and constants for the poisoned range table.
package prt_pkg;

    localparam int MAX_RANGES = 256;
    localparam int ADDR_W     = 32;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int ENTRY_W    = 2 * ADDR_W;
    localparam int STATUS_W   = 2;
    localparam int USED_W     = 9;
    localparam int CMD_W      = 2;
    localparam int S_TDATA_W  = 2 * ADDR_W;
    localparam int M_TDATA_W  = ((STATUS_W + USED_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ENTRY_W-1:0]   entry_t;
    typedef logic [USED_W-1:0]    used_t;
    typedef logic [M_TDATA_W-1:0] mdata_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_POISON   = 2'd0,
        CMD_UNPOISON = 2'd1,
        CMD_CHECK    = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_EVAL  = 6'b000100,
        S_MOVE  = 6'b001000,
        S_SPLIT = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

endpackage

// ===== hdl/prt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/poisoned_range_table.sv =====
// Poisoned range table: append, subtract and overlap check on address ranges.
// Poison and unused commands go from idle straight to the done state, which
// registers the result once the output is free. Unpoison and check walk the
// table entry by entry; a removed entry is refilled through MOVE, a split entry
// appended through SPLIT, each then back to RD. Only one item is handled at a time.
// Reset (aresetn low, synchronous) empties the table; the RAM is not cleared.
module poisoned_range_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [prt_pkg::S_TDATA_W-1:0]   s_tdata,  // addr[31:0], length[63:32]
    input  logic [prt_pkg::CMD_W-1:0]       s_tuser,  // command[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [prt_pkg::M_TDATA_W-1:0]   m_tdata   // status[1:0], entries_used[10:2]
);

    // Control state
    prt_pkg::state_t  state_reg,  state_next;
    prt_pkg::cmd_t    cmd_reg,    cmd_next;
    prt_pkg::status_t status_reg, status_next;
    prt_pkg::cnt_t    count_reg,  count_next;   // valid entries
    prt_pkg::cnt_t    idx_reg,    idx_next;     // walk position
    // Operand and scratch
    prt_pkg::addr_t   lo_reg,     lo_next;      // range start
    prt_pkg::addr_t   hi_reg,     hi_next;      // range end, wrapped
    prt_pkg::addr_t   hold_reg,   hold_next;    // stop of a straddled entry
    // Result register
    logic             m_valid_reg, m_valid_next;
    prt_pkg::status_t m_status_reg, m_status_next;
    prt_pkg::used_t   m_used_reg,  m_used_next;

    // Table RAM: each word is {stop, start}
    logic             wr_en;
    prt_pkg::idx_t    wr_addr;
    prt_pkg::entry_t  wr_data;
    prt_pkg::idx_t    rd_addr;
    prt_pkg::entry_t  rd_data;

    logic             s_accept;
    prt_pkg::cmd_t    in_cmd;
    prt_pkg::addr_t   in_addr;
    prt_pkg::addr_t   in_len;
    prt_pkg::addr_t   in_end;
    prt_pkg::addr_t   ent_start;
    prt_pkg::addr_t   ent_stop;
    prt_pkg::cnt_t    idx_inc;
    prt_pkg::cnt_t    last_idx;
    logic             more_left;
    logic             table_full;
    logic             disjoint;
    logic             covered;
    logic             clip_low;
    logic             clip_high;
    logic             hit;

    prt_ram #(
        .WIDTH (prt_pkg::ENTRY_W),
        .DEPTH (prt_pkg::MAX_RANGES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == prt_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_cmd   = prt_pkg::cmd_t'(s_tuser);
    assign in_addr  = s_tdata[prt_pkg::ADDR_W-1:0];
    assign in_len   = s_tdata[prt_pkg::S_TDATA_W-1:prt_pkg::ADDR_W];
    assign in_end   = in_addr + in_len;   // wraps

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = prt_pkg::mdata_t'({m_used_reg, m_status_reg});

    // Entry under test comes straight from the RAM read register
    assign ent_start  = rd_data[prt_pkg::ADDR_W-1:0];
    assign ent_stop   = rd_data[prt_pkg::ENTRY_W-1:prt_pkg::ADDR_W];
    assign idx_inc    = idx_reg + prt_pkg::cnt_t'(1);
    assign last_idx   = count_reg - prt_pkg::cnt_t'(1);
    assign more_left  = (idx_inc < count_reg);
    assign table_full = (count_reg >= prt_pkg::cnt_t'(prt_pkg::MAX_RANGES));

    // Unsigned compares on wrapped values, as in the table semantics
    assign disjoint  = (hi_reg <= ent_start) || (lo_reg >= ent_stop);
    assign clip_low  = (lo_reg <= ent_start);
    assign clip_high = (hi_reg >= ent_stop);
    assign covered   = clip_low && clip_high;
    assign hit       = (lo_reg < ent_stop) && (hi_reg > ent_start);

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        hold_next     = hold_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_used_next   = m_used_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg[prt_pkg::IDX_W-1:0];
        wr_data       = rd_data;
        rd_addr       = idx_reg[prt_pkg::IDX_W-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            prt_pkg::S_IDLE: begin
                if (s_accept) begin
                    cmd_next    = in_cmd;
                    lo_next     = in_addr;
                    hi_next     = in_end;
                    idx_next    = '0;
                    status_next = prt_pkg::ST_OK;
                    case (in_cmd)
                        prt_pkg::CMD_POISON: begin
                            state_next = prt_pkg::S_DONE;
                            if (in_len != '0) begin
                                if (table_full) begin
                                    status_next = prt_pkg::ST_FULL;
                                end else begin
                                    wr_en      = 1'b1;
                                    wr_addr    = count_reg[prt_pkg::IDX_W-1:0];
                                    wr_data    = {in_end, in_addr};
                                    count_next = count_reg + prt_pkg::cnt_t'(1);
                                end
                            end
                        end
                        prt_pkg::CMD_UNPOISON, prt_pkg::CMD_CHECK: begin
                            state_next = prt_pkg::S_RD;
                        end
                        default: begin
                            state_next = prt_pkg::S_DONE;
                        end
                    endcase
                end
            end
            // (Re)start the walk at idx_reg
            prt_pkg::S_RD: begin
                if (idx_reg < count_reg) begin
                    state_next = prt_pkg::S_EVAL;
                end else begin
                    state_next = prt_pkg::S_DONE;
                end
            end
            prt_pkg::S_EVAL: begin
                if (cmd_reg == prt_pkg::CMD_CHECK && hit) begin
                    status_next = prt_pkg::ST_OVERLAP;
                    state_next  = prt_pkg::S_DONE;
                end else if (cmd_reg == prt_pkg::CMD_CHECK || disjoint) begin
                    idx_next   = idx_inc;
                    rd_addr    = idx_inc[prt_pkg::IDX_W-1:0];
                    state_next = more_left ? prt_pkg::S_EVAL : prt_pkg::S_DONE;
                end else if (covered) begin
                    // fetch the last entry to fill this slot
                    rd_addr    = last_idx[prt_pkg::IDX_W-1:0];
                    state_next = prt_pkg::S_MOVE;
                end else if (clip_low || clip_high) begin
                    wr_en      = 1'b1;
                    wr_data    = clip_low ? {ent_stop, hi_reg} : {lo_reg, ent_start};
                    idx_next   = idx_inc;
                    rd_addr    = idx_inc[prt_pkg::IDX_W-1:0];
                    state_next = more_left ? prt_pkg::S_EVAL : prt_pkg::S_DONE;
                end else if (table_full) begin
                    status_next = prt_pkg::ST_FULL;
                    state_next  = prt_pkg::S_DONE;
                end else begin
                    // straddle: keep lower part here, append upper part next
                    wr_en      = 1'b1;
                    wr_data    = {lo_reg, ent_start};
                    hold_next  = ent_stop;
                    state_next = prt_pkg::S_SPLIT;
                end
            end
            prt_pkg::S_MOVE: begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                count_next = last_idx;
                state_next = prt_pkg::S_RD;
            end
            prt_pkg::S_SPLIT: begin
                wr_en      = 1'b1;
                wr_addr    = count_reg[prt_pkg::IDX_W-1:0];
                wr_data    = {hold_reg, hi_reg};
                count_next = count_reg + prt_pkg::cnt_t'(1);
                idx_next   = idx_inc;
                state_next = prt_pkg::S_RD;
            end
            prt_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_used_next   = prt_pkg::used_t'(count_reg);
                    state_next    = prt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = prt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= prt_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            cmd_reg     <= prt_pkg::CMD_POISON;
            status_reg  <= prt_pkg::ST_OK;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            cmd_reg     <= cmd_next;
            status_reg  <= status_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        hold_reg     <= hold_next;
        m_status_reg <= m_status_next;
        m_used_reg   <= m_used_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= prt_pkg::cnt_t'(prt_pkg::MAX_RANGES))
        else $error("entry count above table size");

    a_eval_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prt_pkg::S_EVAL) |-> (idx_reg < count_reg))
        else $error("walk evaluates a slot past the valid entries");

    a_poison_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_cmd == prt_pkg::CMD_POISON && in_len != '0 && !table_full)
        |=> (count_reg == $past(count_reg) + prt_pkg::cnt_t'(1)))
        else $error("poison item did not append an entry");

    a_overlap_only_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prt_pkg::S_DONE && status_reg == prt_pkg::ST_OVERLAP)
        |-> (cmd_reg == prt_pkg::CMD_CHECK))
        else $error("overlap status from a non-check item");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the poisoned range table.
module testbench;

    localparam logic [prt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_A_ITEMS = 250;
    localparam int PHASE_C_ITEMS = 50;

    typedef struct packed {
        prt_pkg::status_t status;
        prt_pkg::used_t   used;
    } outcome_t;

    typedef struct packed {
        logic [prt_pkg::CMD_W-1:0] cmd;
        prt_pkg::addr_t            addr;
        prt_pkg::addr_t            len;
        bit                        known;
        prt_pkg::status_t          status;
        prt_pkg::used_t            used;
    } plan_row_t;

    // Directed items; rows with known set carry the expected outcome.
    localparam int PLAN_N = 23;
    localparam plan_row_t PLAN [PLAN_N] = '{
        '{prt_pkg::CMD_CHECK,    32'd0,         32'd0,         1'b1, prt_pkg::ST_OK,      9'd0},
        '{prt_pkg::CMD_POISON,   32'd100,       32'd0,         1'b1, prt_pkg::ST_OK,      9'd0},
        '{prt_pkg::CMD_UNPOISON, 32'd0,         32'hFFFF_FFFF, 1'b1, prt_pkg::ST_OK,      9'd0},
        '{prt_pkg::CMD_POISON,   32'd100,       32'd100,       1'b1, prt_pkg::ST_OK,      9'd1},
        '{prt_pkg::CMD_CHECK,    32'd150,       32'd1,         1'b1, prt_pkg::ST_OVERLAP, 9'd1},
        '{prt_pkg::CMD_CHECK,    32'd200,       32'd10,        1'b1, prt_pkg::ST_OK,      9'd1},
        '{prt_pkg::CMD_CHECK,    32'd90,        32'd10,        1'b1, prt_pkg::ST_OK,      9'd1},
        '{prt_pkg::CMD_CHECK,    32'd150,       32'd0,         1'b1, prt_pkg::ST_OVERLAP, 9'd1},
        '{prt_pkg::CMD_UNPOISON, 32'd120,       32'd10,        1'b1, prt_pkg::ST_OK,      9'd2},
        '{prt_pkg::CMD_UNPOISON, 32'd90,        32'd15,        1'b1, prt_pkg::ST_OK,      9'd2},
        '{prt_pkg::CMD_UNPOISON, 32'd190,       32'd20,        1'b1, prt_pkg::ST_OK,      9'd2},
        '{prt_pkg::CMD_UNPOISON, 32'd160,       32'd0,         1'b1, prt_pkg::ST_OK,      9'd3},
        '{prt_pkg::CMD_POISON,   32'd1000,      32'd50,        1'b1, prt_pkg::ST_OK,      9'd4},
        '{prt_pkg::CMD_UNPOISON, 32'd100,       32'd100,       1'b1, prt_pkg::ST_OK,      9'd1},
        '{prt_pkg::CMD_POISON,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, prt_pkg::ST_OK,      9'd0},
        '{prt_pkg::CMD_POISON,   32'hFFFF_FF00, 32'h0000_0200, 1'b0, prt_pkg::ST_OK,      9'd0},
        '{prt_pkg::CMD_CHECK,    32'hFFFF_FFFF, 32'd1,         1'b0, prt_pkg::ST_OK,      9'd0},
        '{prt_pkg::CMD_CHECK,    32'd0,         32'hFFFF_FFFF, 1'b0, prt_pkg::ST_OK,      9'd0},
        '{CMD_UNUSED,            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, prt_pkg::ST_OK,      9'd0},
        '{prt_pkg::CMD_UNPOISON, 32'hFFFF_FF80, 32'h0000_0100, 1'b0, prt_pkg::ST_OK,      9'd0},
        '{prt_pkg::CMD_CHECK,    32'h10,        32'h10,        1'b0, prt_pkg::ST_OK,      9'd0},
        '{prt_pkg::CMD_UNPOISON, 32'd0,         32'hFFFF_FFFF, 1'b0, prt_pkg::ST_OK,      9'd0},
        '{CMD_UNUSED,            32'd0,         32'd0,         1'b0, prt_pkg::ST_OK,      9'd0}
    };

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [prt_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [prt_pkg::CMD_W-1:0]     s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    prt_pkg::mdata_t               m_tdata;

    // Predicted table contents
    prt_pkg::addr_t pois_lo [prt_pkg::MAX_RANGES];
    prt_pkg::addr_t pois_hi [prt_pkg::MAX_RANGES];
    int             pois_count = 0;

    outcome_t expected_outcomes [$];
    int       mismatch_count = 0;
    int       idle_cycles    = 0;
    bit       tx_gaps_on     = 1'b0;
    bit       rx_stalls_on   = 1'b0;

    poisoned_range_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Applies one command to the predicted table and returns its outcome.
    function automatic outcome_t apply_range_cmd(logic [prt_pkg::CMD_W-1:0] cmd,
                                                 prt_pkg::addr_t lo, prt_pkg::addr_t len);
        prt_pkg::addr_t   hi = lo + len;
        prt_pkg::addr_t   s;
        prt_pkg::addr_t   e;
        prt_pkg::status_t st = prt_pkg::ST_OK;
        int               i  = 0;
        case (cmd)
            prt_pkg::CMD_POISON: begin
                if (len == 0) begin
                    st = prt_pkg::ST_OK;
                end else if (pois_count >= prt_pkg::MAX_RANGES) begin
                    st = prt_pkg::ST_FULL;
                end else begin
                    pois_lo[pois_count] = lo;
                    pois_hi[pois_count] = hi;
                    pois_count++;
                end
            end
            prt_pkg::CMD_UNPOISON: begin
                while (i < pois_count && st == prt_pkg::ST_OK) begin
                    s = pois_lo[i];
                    e = pois_hi[i];
                    if (hi <= s || lo >= e) begin
                        i++;
                    end else if (lo <= s && hi >= e) begin
                        // covered: pull in the last entry, look at this slot again
                        pois_lo[i] = pois_lo[pois_count-1];
                        pois_hi[i] = pois_hi[pois_count-1];
                        pois_count--;
                    end else if (lo <= s) begin
                        pois_lo[i] = hi;
                        i++;
                    end else if (hi >= e) begin
                        pois_hi[i] = lo;
                        i++;
                    end else if (pois_count >= prt_pkg::MAX_RANGES) begin
                        st = prt_pkg::ST_FULL;  // split with no room: stop, keep earlier edits
                    end else begin
                        pois_hi[i]          = lo;
                        pois_lo[pois_count] = hi;
                        pois_hi[pois_count] = e;
                        pois_count++;
                        i++;
                    end
                end
            end
            prt_pkg::CMD_CHECK: begin
                for (i = 0; i < pois_count; i++) begin
                    if (lo < pois_hi[i] && hi > pois_lo[i])
                        st = prt_pkg::ST_OVERLAP;
                end
            end
            default: ;
        endcase
        return '{status: st, used: prt_pkg::used_t'(pois_count)};
    endfunction

    function automatic prt_pkg::addr_t rand_addr();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_F000 + $urandom_range(0, 4095);
            default: return $urandom_range(0, 8191);
        endcase
    endfunction

    function automatic prt_pkg::addr_t rand_len();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return $urandom;
            2, 3:    return $urandom_range(0, 16);
            default: return $urandom_range(1, 600);
        endcase
    endfunction

    // Finds a point strictly inside some predicted entry; a zero-length
    // unpoison there splits it.
    function automatic bit pick_interior(output prt_pkg::addr_t point);
        int k;
        int idx;
        point = '0;
        if (pois_count == 0)
            return 1'b0;
        for (k = 0; k < 8; k++) begin
            idx = $urandom_range(0, pois_count - 1);
            if (pois_hi[idx] > pois_lo[idx] + 1) begin
                point = pois_lo[idx] + 1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Presents one item, waits for the handshake, then records its outcome.
    task automatic send_item(logic [prt_pkg::CMD_W-1:0] cmd, prt_pkg::addr_t addr,
                             prt_pkg::addr_t len, bit known = 1'b0, outcome_t typed = '0);
        outcome_t predicted;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {len, addr};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_range_cmd(cmd, addr, len);
        expected_outcomes.push_back(known ? typed : predicted);
    endtask

    // Random command mix over a small window so ranges overlap often.
    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_item(prt_pkg::CMD_POISON, rand_addr(), rand_len());
        else if (r < 65)
            send_item(prt_pkg::CMD_UNPOISON, rand_addr(), rand_len());
        else if (r < 95)
            send_item(prt_pkg::CMD_CHECK, rand_addr(), rand_len());
        else
            send_item(CMD_UNUSED, $urandom, $urandom);
    endtask

    // Sends a zero-length unpoison inside an entry, or a check if none fits.
    task automatic send_split_item();
        prt_pkg::addr_t point;
        if (pick_interior(point))
            send_item(prt_pkg::CMD_UNPOISON, point, '0);
        else
            send_item(prt_pkg::CMD_CHECK, $urandom_range(0, 65535), $urandom_range(0, 64));
    endtask

    // Result side: random ready stalls while enabled.
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_stalls_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Result checker: each accepted item against the oldest expectation.
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outcomes.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: status=%0d used=%0d",
                             m_tdata[1:0], m_tdata[10:2]);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = expected_outcomes.pop_front();
                if (m_tdata[1:0] != want.status || m_tdata[10:2] != want.used) begin
                    if (mismatch_count < 10)
                        $display("mismatch: status exp %0d got %0d, used exp %0d got %0d",
                                 want.status, m_tdata[1:0], want.used, m_tdata[10:2]);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with source and sink stalls on
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        for (n = 0; n < PLAN_N; n++)
            send_item(PLAN[n].cmd, PLAN[n].addr, PLAN[n].len, PLAN[n].known,
                      '{status: PLAN[n].status, used: PLAN[n].used});

        // Random mix; gaps switch on and off in stretches
        for (n = 0; n < PHASE_A_ITEMS; n++) begin
            if (n % 40 == 0) begin
                tx_gaps_on   = ($urandom_range(0, 2) != 0);
                rx_stalls_on = ($urandom_range(0, 2) != 0);
            end
            send_random_item();
        end

        // Hold off until the block has drained everything
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge aclk);

        // Fill the table: mostly small poisons, a few splits and checks
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        n = 0;
        while (pois_count < prt_pkg::MAX_RANGES && n < 800) begin
            case ($urandom_range(0, 19))
                0, 1:    send_item(prt_pkg::CMD_CHECK, $urandom_range(0, 65535),
                                   $urandom_range(0, 64));
                2:       send_split_item();
                default: send_item(prt_pkg::CMD_POISON, $urandom_range(0, 65535),
                                   $urandom_range(1, 64));
            endcase
            n++;
        end

        // Full table: poisons and splits are refused, checks still walk the table
        for (n = 0; n < 16; n++) begin
            case (n % 3)
                0:       send_item(prt_pkg::CMD_POISON, $urandom, $urandom_range(1, 1000));
                1:       send_split_item();
                default: send_item(prt_pkg::CMD_CHECK, $urandom_range(0, 65535),
                                   $urandom_range(0, 64));
            endcase
        end

        // Last stretch without gaps: drain with wide unpoisons
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        for (n = 0; n < PHASE_C_ITEMS; n++) begin
            case ($urandom_range(0, 3))
                0:       send_item(prt_pkg::CMD_CHECK, $urandom_range(0, 65535),
                                   $urandom_range(0, 4096));
                1:       send_item(prt_pkg::CMD_POISON, rand_addr(), rand_len());
                default: send_item(prt_pkg::CMD_UNPOISON, $urandom_range(0, 65535),
                                   $urandom_range(0, 8192));
            endcase
        end
        send_item(prt_pkg::CMD_UNPOISON, '0, 32'hFFFF_FFFF);
        send_item(prt_pkg::CMD_CHECK, '0, 32'hFFFF_FFFF);
        s_tvalid <= 1'b0;

        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
